FILE: rtl/core/tmas_pkg.sv
// Shared types and constants for the trimmed-mean ADC scanner.
package tmas_pkg;

    localparam int BATCH_DEF     = 16;
    localparam int MUX_SLOTS_DEF = 8;

    localparam int SAMPLE_W = 12;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 4;
    localparam int SUM_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int SEL_W    = 3;
    localparam int OPC_W    = 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic KIND_BATCH = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_SAMPLE     = 2'd0,
        OP_READ_VOLT  = 2'd1,
        OP_READ_TABLE = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [SAMPLE_W-1:0]  sample;
        logic [INDEX_W-1:0]   index;
    } cmd_t;

endpackage

FILE: rtl/core/trimmed_mean_adc_scanner_core.sv
// Trimmed-mean ADC scanner: top level joining front end, command queue and back end.
//
// Input channel (s_*): one word per ADC sample or read request. s_tuser carries the
// opcode (sample, read voltage, read switch table); s_tdata carries the sample and
// the table index. Words with an unused opcode are accepted and discarded.
// Result channel (m_*): m_tuser tells a finished batch from a read answer; m_tdata
// carries the value, the ADC channel and the multiplexer select.
// A sample that does not close a batch streams at one per cycle while the back end is
// idle; a read also waits until the result register is free. The last sample of a batch
// steps the back end through accumulation, rest computation, reciprocal multiply, then
// correction and result, and the result step waits while the receiver stalls. Every word
// passes through the front register and the queue before the back end takes it.
// Reset clears the batch accumulators, voltage, switch table and queue and sets the
// multiplexer slot to one. When the receiver stalls, the result register holds its
// word; the back end keeps consuming samples that produce no result, and the queue
// and front register fill before s_tready drops.
module trimmed_mean_adc_scanner_core #(
    parameter int BATCH     = tmas_pkg::BATCH_DEF,
    parameter int MUX_SLOTS = tmas_pkg::MUX_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tmas_pkg::IN_DATA_W-1:0]     s_tdata,   // sample[11:0], table_index[15:12]
    input  logic [tmas_pkg::OPC_W-1:0]         s_tuser,   // opcode[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tmas_pkg::OUT_DATA_W-1:0]    m_tdata,   // value[11:0], adc_channel[12],
                                                          // mux_select[15:13]
    output logic                               m_tuser    // kind[0]
);

    logic           push;
    tmas_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    tmas_pkg::cmd_t q_cmd;

    tmas_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    tmas_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .cmd      (q_cmd)
    );

    tmas_back #(
        .BATCH     (BATCH),
        .MUX_SLOTS (MUX_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/core/tmas_front.sv
// Front end: accepts input words, drops unused opcodes and stages commands for the queue.
module tmas_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tmas_pkg::IN_DATA_W-1:0]     s_tdata,  // sample[11:0], table_index[15:12]
    input  logic [tmas_pkg::OPC_W-1:0]         s_tuser,  // opcode[1:0]
    output logic                               push,
    output tmas_pkg::cmd_t                     push_cmd,
    input  logic                               q_full
);

    logic           cmd_valid_reg, cmd_valid_next;
    tmas_pkg::cmd_t cmd_reg, cmd_next;
    logic           accept;
    logic           keep;
    tmas_pkg::op_t  op_dec;

    assign s_tready = !cmd_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = cmd_valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    always_comb begin
        keep   = 1'b1;
        op_dec = tmas_pkg::OP_SAMPLE;
        unique case (s_tuser)
            tmas_pkg::OP_SAMPLE:     op_dec = tmas_pkg::OP_SAMPLE;
            tmas_pkg::OP_READ_VOLT:  op_dec = tmas_pkg::OP_READ_VOLT;
            tmas_pkg::OP_READ_TABLE: op_dec = tmas_pkg::OP_READ_TABLE;
            default:                 keep   = 1'b0;
        endcase
    end

    always_comb begin
        cmd_valid_next = cmd_valid_reg && !push;
        cmd_next       = cmd_reg;
        if (accept) begin
            // An unused opcode is consumed here and never reaches the back end.
            cmd_valid_next  = keep;
            cmd_next.op     = op_dec;
            cmd_next.sample = s_tdata[tmas_pkg::SAMPLE_W-1:0];
            cmd_next.index  = s_tdata[tmas_pkg::SAMPLE_W +: tmas_pkg::INDEX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

FILE: rtl/core/tmas_queue.sv
// Small command queue between the front end and the back end.
module tmas_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tmas_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output tmas_pkg::cmd_t  cmd
);

    tmas_pkg::cmd_t                 mem [tmas_pkg::QDEPTH];
    logic [tmas_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tmas_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tmas_pkg::QPTR_W:0]      count_reg, count_next;

    assign full  = (count_reg == (tmas_pkg::QPTR_W+1)'(tmas_pkg::QDEPTH));
    assign valid = (count_reg != '0);
    assign cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/tmas_back.sv
// Back end: batch accumulation, trimmed-mean division, state updates and result register.
module tmas_back #(
    parameter int BATCH     = tmas_pkg::BATCH_DEF,
    parameter int MUX_SLOTS = tmas_pkg::MUX_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  tmas_pkg::cmd_t                     q_cmd,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tmas_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tuser
);

    localparam int DIV     = (BATCH > 2) ? BATCH - 2 : 1;
    localparam int FRAC    = 20;
    localparam int RECIP   = (1 << FRAC) / DIV;
    localparam int RECIP_W = FRAC + 1;
    localparam int PROD_W  = tmas_pkg::SUM_W + RECIP_W;
    localparam int DIV_W   = 4;
    localparam int CHK_W   = tmas_pkg::SUM_W + DIV_W;
    localparam int TW      = (MUX_SLOTS > 1) ? $clog2(MUX_SLOTS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_REST, ST_MUL, ST_FIN} state_t;

    state_t                            state_reg;
    logic [tmas_pkg::COUNT_W-1:0]      count_reg;
    logic [tmas_pkg::SUM_W-1:0]        sum_reg;
    logic [tmas_pkg::SAMPLE_W-1:0]     max_reg;
    logic [tmas_pkg::SAMPLE_W-1:0]     min_reg;
    logic                              chan_reg;
    logic [tmas_pkg::SAMPLE_W-1:0]     volt_reg;
    logic [tmas_pkg::SLOT_W-1:0]       slot_reg;
    logic [tmas_pkg::SAMPLE_W-1:0]     table_mem [MUX_SLOTS];
    logic [tmas_pkg::SUM_W-1:0]        rest_reg;
    logic [PROD_W-1:0]                 prod_reg;
    logic                              m_tvalid_reg;
    logic [tmas_pkg::OUT_DATA_W-1:0]   m_tdata_reg;
    logic                              m_tuser_reg;

    logic                              out_free;
    logic                              out_load;
    logic                              is_sample;
    logic                              is_last;
    logic [tmas_pkg::SAMPLE_W-1:0]     max_new, min_new;
    logic [tmas_pkg::SUM_W-1:0]        sum_new;
    logic [tmas_pkg::INDEX_W-1:0]      idx_m1;
    logic                              idx_ok;
    logic [tmas_pkg::SAMPLE_W-1:0]     read_val;
    logic [tmas_pkg::SLOT_W-1:0]       slot_m1, slot_adv, slot_adv_m1;
    logic [tmas_pkg::SUM_W-1:0]        q0;
    logic [CHK_W-1:0]                  rem;
    logic [tmas_pkg::SUM_W-1:0]        quot;
    logic [tmas_pkg::SAMPLE_W-1:0]     result;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_sample = (q_cmd.op == tmas_pkg::OP_SAMPLE);
    assign is_last   = ({1'b0, count_reg} == (tmas_pkg::COUNT_W+1)'(BATCH - 1));
    assign q_pop     = (state_reg == ST_IDLE) && q_valid && (is_sample || out_free);
    assign out_load  = (q_pop && !is_sample) || ((state_reg == ST_FIN) && out_free);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        max_new = (q_cmd.sample > max_reg) ? q_cmd.sample : max_reg;
        min_new = (q_cmd.sample < min_reg) ? q_cmd.sample : min_reg;
        sum_new = sum_reg + tmas_pkg::SUM_W'(q_cmd.sample);
    end

    always_comb begin
        idx_m1   = q_cmd.index - 1'b1;
        idx_ok   = (q_cmd.index != '0) &&
                   ({1'b0, q_cmd.index} <= (tmas_pkg::INDEX_W+1)'(MUX_SLOTS));
        read_val = '0;
        if (q_cmd.op == tmas_pkg::OP_READ_VOLT) begin
            read_val = volt_reg;
        end else if (idx_ok) begin
            read_val = table_mem[idx_m1[TW-1:0]];
        end
    end

    always_comb begin
        slot_m1     = slot_reg - 1'b1;
        slot_adv    = (slot_reg == tmas_pkg::SLOT_W'(MUX_SLOTS)) ? tmas_pkg::SLOT_W'(1)
                                                                 : slot_reg + 1'b1;
        slot_adv_m1 = slot_adv - 1'b1;
    end

    // The reciprocal estimate is low by at most one; a single compare fixes it.
    always_comb begin
        q0   = prod_reg[FRAC +: tmas_pkg::SUM_W];
        rem  = CHK_W'(rest_reg) - CHK_W'(q0) * CHK_W'(DIV);
        quot = (rem >= CHK_W'(DIV)) ? q0 + 1'b1 : q0;
        result = (BATCH > 2) ? quot[tmas_pkg::SAMPLE_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            sum_reg      <= '0;
            max_reg      <= '0;
            min_reg      <= '1;
            chan_reg     <= 1'b0;
            volt_reg     <= '0;
            slot_reg     <= tmas_pkg::SLOT_W'(1);
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MUX_SLOTS; i++) begin
                table_mem[i] <= '0;
            end
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        if (is_sample) begin
                            max_reg   <= max_new;
                            min_reg   <= min_new;
                            sum_reg   <= sum_new;
                            count_reg <= is_last ? '0 : count_reg + 1'b1;
                            if (is_last) begin
                                state_reg <= ST_REST;
                            end
                        end else begin
                            m_tuser_reg  <= tmas_pkg::KIND_READ;
                            m_tdata_reg  <= {slot_m1[tmas_pkg::SEL_W-1:0], chan_reg, read_val};
                        end
                    end
                end
                ST_REST: begin
                    rest_reg  <= sum_reg - tmas_pkg::SUM_W'(max_reg)
                                         - tmas_pkg::SUM_W'(min_reg);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(rest_reg) * PROD_W'(RECIP);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tuser_reg  <= tmas_pkg::KIND_BATCH;
                        if (chan_reg == 1'b0) begin
                            volt_reg    <= result;
                            m_tdata_reg <= {slot_m1[tmas_pkg::SEL_W-1:0], chan_reg, result};
                        end else begin
                            table_mem[slot_m1[TW-1:0]] <= result;
                            slot_reg    <= slot_adv;
                            m_tdata_reg <= {slot_adv_m1[tmas_pkg::SEL_W-1:0], chan_reg, result};
                        end
                        chan_reg  <= !chan_reg;
                        count_reg <= '0;
                        sum_reg   <= '0;
                        max_reg   <= '0;
                        min_reg   <= '1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_count_in_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, count_reg} < (tmas_pkg::COUNT_W+1)'(BATCH))
        else $error("batch counter passed the batch length");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_reg != '0) && (slot_reg <= tmas_pkg::SLOT_W'(MUX_SLOTS)))
        else $error("multiplexer slot out of range");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("command taken while a division is in progress");

    a_fin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=>
            (m_tvalid_reg && m_tuser_reg == tmas_pkg::KIND_BATCH && state_reg == ST_IDLE))
        else $error("finished batch did not produce a result word");

endmodule
